/* rtl/hcvg_pkg.sv */
// Package for the Hilbert curve vertex generator: widths, direction codes,
// sub-curve tables, register indexes and the per-digit displacement function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcvg_pkg;

    localparam int COORD_W       = 17;
    localparam int LVL_W         = 5;
    localparam int ORI_W         = 2;
    localparam int DEF_MAX_LEVEL = 16;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 40;

    // register index is paddr[2]
    localparam logic REG_CURVE_LEVEL = 1'b0;
    localparam logic REG_START_ORIENT = 1'b1;

    localparam logic [LVL_W-1:0] LEVEL_RESET = LVL_W'(1);

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    localparam t_dir CHILD_DIR [4][4] = '{
        '{DIR_LEFT,  DIR_UP,    DIR_UP,    DIR_RIGHT},
        '{DIR_UP,    DIR_LEFT,  DIR_LEFT,  DIR_DOWN},
        '{DIR_RIGHT, DIR_DOWN,  DIR_DOWN,  DIR_LEFT},
        '{DIR_DOWN,  DIR_RIGHT, DIR_RIGHT, DIR_UP}
    };

    localparam t_dir JOIN_MOVE [4][3] = '{
        '{DIR_DOWN,  DIR_RIGHT, DIR_UP},
        '{DIR_RIGHT, DIR_DOWN,  DIR_LEFT},
        '{DIR_UP,    DIR_LEFT,  DIR_DOWN},
        '{DIR_LEFT,  DIR_UP,    DIR_RIGHT}
    };

    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
    } t_xy;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_dir               dir;
        logic               is_last;
        logic               past_end;
    } t_cell_pay;

    // displacement of the first q sub-curves of a curve of direction d,
    // each sub-curve spanning 'span' steps, plus the joining unit moves
    function automatic t_xy cell_step(input t_dir d, input logic [1:0] q,
                                      input logic [COORD_W-1:0] span);
        t_xy  acc;
        t_dir c;
        t_dir m;
        acc = '0;
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < q) begin
                c = CHILD_DIR[d][2'(j)];
                m = JOIN_MOVE[d][2'(j)];
                case (c)
                    DIR_UP:   acc.dx = acc.dx + span;
                    DIR_LEFT: acc.dy = acc.dy + span;
                    DIR_DOWN: acc.dx = acc.dx - span;
                    default:  acc.dy = acc.dy - span;
                endcase
                case (m)
                    DIR_UP:   acc.dy = acc.dy - COORD_W'(1);
                    DIR_LEFT: acc.dx = acc.dx - COORD_W'(1);
                    DIR_DOWN: acc.dy = acc.dy + COORD_W'(1);
                    default:  acc.dx = acc.dx + COORD_W'(1);
                endcase
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* rtl/hcvg_cell.sv */
// One cell of the digit chain: resolves one base-4 digit of the vertex index
// and hands position, direction and remaining digits to the next cell.
// Depends on hcvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcvg_cell #(
    parameter int K     = 1,
    parameter int IDX_W = 2
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire [hcvg_pkg::LVL_W-1:0]      i_lvl,
    input  wire                            i_valid,
    input  wire [IDX_W-1:0]                i_idx,
    input  hcvg_pkg::t_cell_pay            i_pay,
    output logic                           o_valid,
    output logic [IDX_W-1:0]               o_idx,
    output hcvg_pkg::t_cell_pay            o_pay
);
    import hcvg_pkg::*;

    localparam logic [COORD_W-1:0] SPAN = COORD_W'((64'(1) << (K - 1)) - 64'(1));

    logic                 r_valid;
    logic [IDX_W-1:0]     r_idx;
    t_cell_pay            r_pay;
    logic [IDX_W-1:0]     n_idx;
    t_cell_pay            n_pay;
    logic [1:0]           w_q;
    logic                 w_active;
    t_xy                  w_step;

    assign w_q      = i_idx[IDX_W-1 -: 2];
    assign w_active = (LVL_W'(K) <= i_lvl);
    assign w_step   = cell_step(i_pay.dir, w_q, SPAN);

    always_comb begin
        n_pay = i_pay;
        n_idx = i_idx << 2;
        if (w_active) begin
            n_pay.x   = i_pay.x + w_step.dx;
            n_pay.y   = i_pay.y + w_step.dy;
            n_pay.dir = CHILD_DIR[i_pay.dir][w_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= n_idx;
            r_pay <= n_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_pay   = r_pay;

endmodule

`default_nettype wire

/* rtl/hilbert_curve_vertex_generator_core.sv */
// The path from the input transfer to o_m_tvalid runs through the
// MAX_LEVEL cell registers and then the output register.
// Throughput: one vertex per cycle; the index counter updates on each transfer
// and a chain of MAX_LEVEL digit cells, one level each, forms the coordinates.
// A stall on the output freezes the whole chain and drops o_s_tready.
// Synchronous active-low reset: walk restarts at vertex 0, chain empties,
// curve_level = 1, start_orientation = 0. Depends on hcvg_pkg, hcvg_cell.
`timescale 1ns / 1ps
`default_nettype none

module hilbert_curve_vertex_generator_core #(
    parameter int MAX_LEVEL = hcvg_pkg::DEF_MAX_LEVEL
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration
    input  wire                               i_psel,
    input  wire                               i_penable,
    input  wire                               i_pwrite,
    input  wire [hcvg_pkg::ADDR_W-1:0]        i_paddr,
    input  wire [hcvg_pkg::DATA_W-1:0]        i_pwdata,
    output logic [hcvg_pkg::DATA_W-1:0]       o_prdata,
    output logic                              o_pready,
    // request stream
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire [hcvg_pkg::S_TDATA_W-1:0]     i_s_tdata,  // [0] restart
    // vertex stream
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [hcvg_pkg::M_TDATA_W-1:0]    o_m_tdata,  // [16:0] grid_x, [33:17] grid_y
    output logic                              o_m_tlast,  // is_last_vertex
    output logic                              o_m_tuser   // past_end
);
    import hcvg_pkg::*;

    localparam int CNT_W = 2 * MAX_LEVEL + 1;
    localparam int DIG_W = 2 * MAX_LEVEL;

    logic [LVL_W-1:0]   r_level;
    logic [ORI_W-1:0]   r_orient;
    logic [CNT_W-1:0]   r_idx;
    logic               r_fin;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic               r_out_last;
    logic               r_out_past;
    logic [COORD_W-1:0] r_last_x;
    logic [COORD_W-1:0] r_last_y;

    logic [CNT_W-1:0]   n_idx;
    logic               n_fin;

    logic               w_en;
    logic               w_accept;
    logic               w_cfg_wr;
    logic [LVL_W-1:0]   w_eff_lvl;
    logic [CNT_W-1:0]   w_cur_idx;
    logic               w_cur_fin;
    logic [CNT_W-1:0]   w_last_idx;
    logic               w_fin_now;
    logic               w_hit_last;

    logic               w_valid [0:MAX_LEVEL];
    logic [DIG_W-1:0]   w_idx   [0:MAX_LEVEL];
    t_cell_pay          w_pay   [0:MAX_LEVEL];

    // configuration port
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;

    always_comb begin
        case (i_paddr[2])
            REG_CURVE_LEVEL:  o_prdata = DATA_W'(r_level);
            REG_START_ORIENT: o_prdata = DATA_W'(r_orient);
            default:          o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= LEVEL_RESET;
            r_orient <= '0;
        end else if (w_cfg_wr) begin
            case (i_paddr[2])
                REG_CURVE_LEVEL:  r_level  <= i_pwdata[LVL_W-1:0];
                REG_START_ORIENT: r_orient <= i_pwdata[ORI_W-1:0];
                default:          r_level  <= r_level;
            endcase
        end
    end

    // index counter
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;
    assign w_accept   = i_s_tvalid && w_en;
    assign w_eff_lvl  = (r_level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : r_level;

    always_comb begin
        w_cur_idx  = i_s_tdata[0] ? '0 : r_idx;
        w_cur_fin  = i_s_tdata[0] ? 1'b0 : r_fin;
        w_last_idx = ~({CNT_W{1'b1}} << {w_eff_lvl, 1'b0});
        w_fin_now  = w_cur_fin || ((w_cur_idx & ~w_last_idx) != '0);
        w_hit_last = !w_fin_now && (w_cur_idx == w_last_idx);
        n_fin      = w_fin_now || w_hit_last;
        n_idx      = n_fin ? w_cur_idx : w_cur_idx + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_fin <= 1'b0;
        end else if (w_accept) begin
            r_idx <= n_idx;
            r_fin <= n_fin;
        end
    end

    // digit chain, top level first
    assign w_valid[0]        = w_accept;
    assign w_idx[0]          = w_cur_idx[DIG_W-1:0];
    assign w_pay[0].x        = '0;
    assign w_pay[0].y        = '0;
    assign w_pay[0].dir      = t_dir'(r_orient);
    assign w_pay[0].is_last  = w_hit_last;
    assign w_pay[0].past_end = w_fin_now;

    for (genvar g = 0; g < MAX_LEVEL; g++) begin : g_cell
        hcvg_cell #(
            .K     (MAX_LEVEL - g),
            .IDX_W (DIG_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_lvl   (w_eff_lvl),
            .i_valid (w_valid[g]),
            .i_idx   (w_idx[g]),
            .i_pay   (w_pay[g]),
            .o_valid (w_valid[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_pay   (w_pay[g+1])
        );
    end

    // output register; past-end items repeat the last vertex given
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
        end else if (w_en) begin
            r_out_valid <= w_valid[MAX_LEVEL];
            if (w_valid[MAX_LEVEL] && !w_pay[MAX_LEVEL].past_end) begin
                r_last_x <= w_pay[MAX_LEVEL].x;
                r_last_y <= w_pay[MAX_LEVEL].y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_valid[MAX_LEVEL]) begin
            r_out_last <= w_pay[MAX_LEVEL].is_last;
            r_out_past <= w_pay[MAX_LEVEL].past_end;
            if (w_pay[MAX_LEVEL].past_end) begin
                r_out_x <= r_last_x;
                r_out_y <= r_last_y;
            end else begin
                r_out_x <= w_pay[MAX_LEVEL].x;
                r_out_y <= w_pay[MAX_LEVEL].y;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - 2 * COORD_W)'(0), r_out_y, r_out_x};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_past;

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tlast && o_m_tuser))
        else $error("last vertex and past-end flagged together");

    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_s_tdata[0] && r_fin) |=> r_fin)
        else $error("finished walk resumed without restart");

    a_restart_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tdata[0]) |=> (r_idx == CNT_W'(1) || r_fin))
        else $error("restart did not return walk to start");

    a_past_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (r_out_x == r_last_x && r_out_y == r_last_y))
        else $error("past-end transfer does not repeat last vertex");

endmodule

`default_nettype wire
